@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/ictf_pkg.sv @@
// ----------------------------------------------------------------------------
// ictf_pkg
// Types, constants and helpers of the complementary tilt filter.
// ----------------------------------------------------------------------------
package ictf_pkg;

  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int TABLE_FRAC       = 24;
  localparam int CORDIC_STEPS_DEF = 18;

  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 17;
  localparam int GAIN_W      = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int ANGLE_W     = 25;

  localparam int ACCEL_SHIFT = 16;
  localparam int CW          = 35;
  localparam int ZW          = 34;
  localparam int ACC_W       = 26;
  localparam int ATAN_W      = 30;
  localparam int TAB_IDX_W   = 5;

  localparam int SQRT_IN_W   = 32;
  localparam int SQRT_W      = 32;
  localparam int SQRT_CNT_W  = $clog2(SQRT_W);

  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 18;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int RND_W       = PROD_W - 16;
  localparam int DELTA_W     = 33;
  localparam int DIFF_W      = 34;
  localparam int BLEND_W     = RND_W + 1;
  localparam int GYRO_SHIFT  = 32 - ANGLE_FRAC_BITS;
  localparam int BLEND_SHIFT = 16;

  localparam int YAW_W         = 36;
  localparam int YAW_MOD_STEPS = 9;
  localparam int YAW_K_W       = $clog2(YAW_MOD_STEPS);

  localparam int LIM_VAL = 180 << ANGLE_FRAC_BITS;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(LIM_VAL);
  localparam logic signed [YAW_W-1:0]   HALF_TURN = YAW_W'(LIM_VAL);
  localparam logic signed [YAW_W-1:0]   FULL_TURN = YAW_W'(2 * LIM_VAL);
  localparam logic signed [YAW_W-1:0]   YAW_NEG_FIX =
    YAW_W'(64'd360 << (ANGLE_FRAC_BITS + YAW_MOD_STEPS - 1));

  localparam logic signed [ZW-1:0] QUARTER_Q24 = ZW'(90 << TABLE_FRAC);

  localparam logic [WEIGHT_W-1:0] ALPHA_ONE        = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST = WEIGHT_W'(64225);
  localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST    = GAIN_W'(163929);

  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_WEIGHT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_GYRO_STEP_GAIN = CFG_INDEX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT_GO,
    ST_GAIN_Y,
    ST_GAIN_Z,
    ST_YAW_SUM,
    ST_YAW_MOD,
    ST_WAIT_ROLL,
    ST_WAIT_PITCH,
    ST_BLEND_R,
    ST_ROLL_DONE
  } ictf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [ATAN_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
    case (idx)
      5'd0:    return ATAN_W'(754974720);
      5'd1:    return ATAN_W'(445687602);
      5'd2:    return ATAN_W'(235489089);
      5'd3:    return ATAN_W'(119537938);
      5'd4:    return ATAN_W'(60000934);
      5'd5:    return ATAN_W'(30029717);
      5'd6:    return ATAN_W'(15018523);
      5'd7:    return ATAN_W'(7509720);
      5'd8:    return ATAN_W'(3754917);
      5'd9:    return ATAN_W'(1877466);
      5'd10:   return ATAN_W'(938734);
      5'd11:   return ATAN_W'(469367);
      5'd12:   return ATAN_W'(234684);
      5'd13:   return ATAN_W'(117342);
      5'd14:   return ATAN_W'(58671);
      5'd15:   return ATAN_W'(29335);
      5'd16:   return ATAN_W'(14668);
      5'd17:   return ATAN_W'(7334);
      5'd18:   return ATAN_W'(3667);
      5'd19:   return ATAN_W'(1833);
      5'd20:   return ATAN_W'(917);
      5'd21:   return ATAN_W'(458);
      5'd22:   return ATAN_W'(229);
      5'd23:   return ATAN_W'(115);
      default: return '0;
    endcase
  endfunction

  // round half up, then floor shift
  function automatic logic signed [RND_W-1:0] round_prod(
    input logic signed [PROD_W-1:0] p,
    input int unsigned sh
  );
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (sh - 1));
    return RND_W'(t >>> sh);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] blend_sat(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [BLEND_W-1:0] v;
    v = BLEND_W'(acc) + BLEND_W'(round_prod(p, BLEND_SHIFT));
    if (v > BLEND_W'(LIM_VAL)) begin
      v = BLEND_W'(LIM_VAL);
    end
    if (v < -BLEND_W'(LIM_VAL)) begin
      v = -BLEND_W'(LIM_VAL);
    end
    return ANGLE_W'(v);
  endfunction

endpackage

@@ sv/ictf_isqrt.sv @@
// ----------------------------------------------------------------------------
// ictf_isqrt
// Floor square root of radicand * 2^32, one root bit per cycle.
// ----------------------------------------------------------------------------
module ictf_isqrt import ictf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SQRT_IN_W-1:0] radicand,
  output unit_stat_t           stat,
  output logic [SQRT_W-1:0]    root
);

  logic [SQRT_IN_W-1:0]  rad;
  logic [SQRT_W:0]       resid;
  logic [SQRT_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;

  logic [SQRT_W+2:0] cur;
  logic [SQRT_W+2:0] trial;
  logic              take;
  logic [SQRT_W+2:0] diff;

  assign cur   = {resid, rad[SQRT_IN_W-1 -: 2]};
  assign trial = (SQRT_W + 3)'({root, 2'b01});
  assign take  = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == SQRT_CNT_W'(SQRT_W - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      resid <= '0;
      root  <= '0;
      cnt   <= '0;
    end else if (busy) begin
      rad   <= rad << 2;
      resid <= take ? diff[SQRT_W:0] : cur[SQRT_W:0];
      root  <= {root[SQRT_W-2:0], take};
      cnt   <= cnt + SQRT_CNT_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ sv/ictf_cordic.sv @@
// ----------------------------------------------------------------------------
// ictf_cordic
// Vectoring CORDIC, atan2(y, x) in degrees, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ictf_cordic import ictf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CW-1:0]    y_in,
  input  logic signed [CW-1:0]    x_in,
  output unit_stat_t              stat,
  output logic signed [ACC_W-1:0] angle
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic                 done;
  logic                 zero_vec;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] tab;
  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;
  logic signed [ZW-1:0] z_next;
  logic signed [ZW-1:0] z_rnd;
  logic                 last;

  assign xs   = x >>> cnt;
  assign ys   = y >>> cnt;
  assign tab  = ZW'(atan_q24(TAB_IDX_W'(cnt)));
  assign last = cnt == STEP_W'(CORDIC_STEPS - 1);

  always_comb begin
    if (!y[CW-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + tab;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - tab;
    end
    z_rnd = z_next + ZW'(1 << (TABLE_FRAC - ANGLE_FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && last) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= '0;
      zero_vec <= (x_in == '0) && (y_in == '0);
      if (!x_in[CW-1]) begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end else if (!y_in[CW-1]) begin
        x <= y_in;
        y <= -x_in;
        z <= QUARTER_Q24;
      end else begin
        x <= -y_in;
        y <= x_in;
        z <= -QUARTER_Q24;
      end
    end else if (busy) begin
      x   <= x_next;
      y   <= y_next;
      z   <= z_next;
      cnt <= cnt + STEP_W'(1);
      if (last) begin
        angle <= zero_vec ? '0 : ACC_W'(z_rnd >>> (TABLE_FRAC - ANGLE_FRAC_BITS));
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ sv/imu_complementary_tilt_filter.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary pitch and roll filter, with gyro-integrated yaw, over raw six-axis samples.
// ----------------------------------------------------------------------------
// Usage
//   Sample channel (sample_valid / sample_stall) takes one six-axis request:
//   three accelerometer and three gyro readings, signed 16 bit.
//   Result channel (result_valid / result_stall) returns pitch, roll and yaw
//   as signed Q16 degrees, one result per sample.
//   Configuration channel (cfg_valid / cfg_ready, always ready) writes
//   blend_weight at index 0 and gyro_step_gain at index 1; other indexes drop.
//   A new sample can be taken in the cycle after the result is loaded, so
//   samples are worked on one at a time.
//   The rate is set by the bit-serial square root followed by the pitch
//   pass of the shared CORDIC unit; roll and yaw overlap with the root.
//   sample_stall stays high while a sample is in work.
//   The result sits in an output register; a stalled result holds, and the
//   next sample is worked on meanwhile, finishing once that register frees.
//   Reset clears the angles, restores the register defaults and empties the
//   output register.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter import ictf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic signed [SAMPLE_W-1:0] accel_x,
  input  logic signed [SAMPLE_W-1:0] accel_y,
  input  logic signed [SAMPLE_W-1:0] accel_z,
  input  logic signed [SAMPLE_W-1:0] gyro_x,
  input  logic signed [SAMPLE_W-1:0] gyro_y,
  input  logic signed [SAMPLE_W-1:0] gyro_z,

  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [ANGLE_W-1:0] pitch_deg,
  output logic signed [ANGLE_W-1:0] roll_deg,
  output logic signed [ANGLE_W-1:0] yaw_deg,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  ictf_state_t state;
  ictf_state_t state_next;

  logic [WEIGHT_W-1:0] blend_weight;
  logic [GAIN_W-1:0]   gyro_step_gain;

  logic signed [SAMPLE_W-1:0] ax;
  logic signed [SAMPLE_W-1:0] ay;
  logic signed [SAMPLE_W-1:0] az;
  logic signed [SAMPLE_W-1:0] gx;
  logic signed [SAMPLE_W-1:0] gy;
  logic signed [SAMPLE_W-1:0] gz;

  logic signed [ANGLE_W-1:0] pitch;
  logic signed [ANGLE_W-1:0] roll;
  logic signed [ANGLE_W-1:0] yaw;

  logic signed [PROD_W-1:0]  prod;
  logic [SQRT_IN_W-1:0]      sumsq;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic signed [ACC_W-1:0]   racc;
  logic signed [YAW_W-1:0]   ymod;
  logic [YAW_K_W-1:0]        ymod_k;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic                       cordic_start;
  logic signed [CW-1:0]       cordic_y;
  logic signed [CW-1:0]       cordic_x;
  unit_stat_t                 cordic_st;
  logic signed [ACC_W-1:0]    cordic_angle;
  logic                       sqrt_start;
  logic [SQRT_IN_W-1:0]       radicand;
  unit_stat_t                 sqrt_st;
  logic [SQRT_W-1:0]          sqrt_root;
  logic                       load_out;
  logic                       out_free;

  logic [WEIGHT_W-1:0]        alpha;
  logic signed [RND_W-1:0]    gyro_delta;
  logic signed [YAW_W-1:0]    yaw_sum;
  logic signed [YAW_W-1:0]    yaw_wrap;
  logic signed [YAW_W-1:0]    yaw_sub;
  logic signed [YAW_W-1:0]    ymod_step;
  logic signed [DIFF_W-1:0]   pitch_diff;
  logic signed [DIFF_W-1:0]   roll_diff;
  logic signed [ANGLE_W-1:0]  pitch_new;
  logic signed [ANGLE_W-1:0]  roll_new;

  ictf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .y_in  (cordic_y),
    .x_in  (cordic_x),
    .stat  (cordic_st),
    .angle (cordic_angle)
  );

  ictf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .stat     (sqrt_st),
    .root     (sqrt_root)
  );

  assign cfg_ready    = 1'b1;
  assign sample_stall = state != ST_IDLE;
  assign out_free     = !result_valid || !result_stall;

  assign alpha      = (blend_weight > ALPHA_ONE) ? ALPHA_ONE : blend_weight;
  assign gyro_delta = round_prod(prod, GYRO_SHIFT);
  assign radicand   = sumsq + prod[SQRT_IN_W-1:0];

  assign yaw_sum   = YAW_W'(yaw) + YAW_W'(gyro_delta) + HALF_TURN;
  assign yaw_wrap  = yaw_sum[YAW_W-1] ? yaw_sum + YAW_NEG_FIX : yaw_sum;
  assign yaw_sub   = FULL_TURN <<< ymod_k;
  assign ymod_step = (ymod >= yaw_sub) ? ymod - yaw_sub : ymod;

  assign pitch_diff = DIFF_W'(pitch) + DIFF_W'(delta_x) - DIFF_W'(cordic_angle);
  assign roll_diff  = DIFF_W'(roll) + DIFF_W'(delta_y) - DIFF_W'(racc);
  assign pitch_new  = blend_sat(cordic_angle, prod);
  assign roll_new   = blend_sat(racc, prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    cordic_y     = '0;
    cordic_x     = '0;
    sqrt_start   = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        mul_en       = 1'b1;
        mul_a        = MUL_A_W'(ay);
        mul_b        = MUL_B_W'(ay);
        cordic_start = 1'b1;
        cordic_y     = CW'(ay) <<< ACCEL_SHIFT;
        cordic_x     = CW'(az) <<< ACCEL_SHIFT;
        state_next   = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(az);
        mul_b      = MUL_B_W'(az);
        state_next = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(gyro_step_gain);
        mul_b      = MUL_B_W'(gx);
        state_next = ST_GAIN_Y;
      end
      ST_GAIN_Y: begin
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(gyro_step_gain);
        mul_b      = MUL_B_W'(gy);
        state_next = ST_GAIN_Z;
      end
      ST_GAIN_Z: begin
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(gyro_step_gain);
        mul_b      = MUL_B_W'(gz);
        state_next = ST_YAW_SUM;
      end
      ST_YAW_SUM: begin
        state_next = ST_YAW_MOD;
      end
      ST_YAW_MOD: begin
        if (ymod_k == '0) begin
          state_next = ST_WAIT_ROLL;
        end
      end
      ST_WAIT_ROLL: begin
        if (cordic_st.done && !cordic_st.busy && sqrt_st.done) begin
          cordic_start = 1'b1;
          cordic_y     = -(CW'(ax) <<< ACCEL_SHIFT);
          cordic_x     = CW'(sqrt_root);
          state_next   = ST_WAIT_PITCH;
        end
      end
      ST_WAIT_PITCH: begin
        if (cordic_st.done) begin
          mul_en     = 1'b1;
          mul_a      = pitch_diff;
          mul_b      = MUL_B_W'(alpha);
          state_next = ST_BLEND_R;
        end
      end
      ST_BLEND_R: begin
        mul_en     = 1'b1;
        mul_a      = roll_diff;
        mul_b      = MUL_B_W'(alpha);
        state_next = ST_ROLL_DONE;
      end
      ST_ROLL_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight   <= BLEND_WEIGHT_RST;
      gyro_step_gain <= GYRO_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLEND_WEIGHT:   blend_weight   <= cfg_data[WEIGHT_W-1:0];
        REG_GYRO_STEP_GAIN: gyro_step_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state == ST_IDLE && sample_valid) begin
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
      gx <= gyro_x;
      gy <= gyro_y;
      gz <= gyro_z;
    end
    case (state)
      ST_SQ_Z:   sumsq   <= prod[SQRT_IN_W-1:0];
      ST_GAIN_Y: delta_x <= DELTA_W'(gyro_delta);
      ST_GAIN_Z: delta_y <= DELTA_W'(gyro_delta);
      ST_YAW_SUM: begin
        ymod   <= yaw_wrap;
        ymod_k <= YAW_K_W'(YAW_MOD_STEPS - 1);
      end
      ST_YAW_MOD: begin
        ymod   <= ymod_step;
        ymod_k <= ymod_k - YAW_K_W'(1);
      end
      ST_WAIT_ROLL: begin
        if (cordic_start) begin
          racc <= cordic_angle;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      pitch_deg <= pitch;
      roll_deg  <= roll_new;
      yaw_deg   <= yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch        <= '0;
      roll         <= '0;
      yaw          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_YAW_MOD && ymod_k == '0) begin
        yaw <= ANGLE_W'(ymod_step - HALF_TURN);
      end
      if (state == ST_BLEND_R) begin
        pitch <= pitch_new;
      end
      if (load_out) begin
        roll         <= roll_new;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/ictf_checker.sv @@
// ----------------------------------------------------------------------------
// ictf_checker
// Port-level checks of the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ictf_checker import ictf_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      sample_valid,
  input logic                      sample_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic signed [ANGLE_W-1:0] pitch_deg,
  input logic signed [ANGLE_W-1:0] roll_deg,
  input logic signed [ANGLE_W-1:0] yaw_deg
);

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(pitch_deg) && $stable(roll_deg) && $stable(yaw_deg))

  `ASSERT_NEXT(a_one_request, clk, rst, sample_valid && !sample_stall, sample_stall)

  `ASSERT_IMPLIES(a_tilt_range, clk, rst, result_valid, pitch_deg <= ANGLE_LIM && pitch_deg >= -ANGLE_LIM && roll_deg <= ANGLE_LIM && roll_deg >= -ANGLE_LIM)

  `ASSERT_IMPLIES(a_yaw_range, clk, rst, result_valid, yaw_deg < ANGLE_LIM && yaw_deg >= -ANGLE_LIM)

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .pitch_deg    (pitch_deg),
  .roll_deg     (roll_deg),
  .yaw_deg      (yaw_deg)
);
